// ===== hdl/cbaf_pkg.sv =====
// shared constants, types and helper functions of the cubic bezier flattener
// no dependencies; every other file of the block uses this package
`timescale 1ns / 1ps
package cbaf_pkg;

    localparam int MAX_DEPTH  = 5;
    localparam int COORD_BITS = 32;
    localparam int CW         = COORD_BITS;
    localparam int DW         = CW + 1;
    localparam int STACK_CAP  = MAX_DEPTH + 1;
    localparam int IDX_W      = $clog2(STACK_CAP);
    localparam int SP_W       = $clog2(STACK_CAP + 1);
    localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
    localparam int OW         = 2 * CW + 3;
    localparam int PW         = 2 * OW;
    localparam int CNT_W      = $clog2(OW + 1);
    localparam int IO_W       = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int VCNT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_TOL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_EPS = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     TOL_RESET     = CFG_W'(410);
    localparam logic [CFG_W-1:0]     EPS_RESET     = CFG_W'(17);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_WB,
        OP_CROSS,
        OP_SPLIT,
        OP_POP,
        OP_CAND_END,
        OP_TAKE_FIRST,
        OP_EMIT_KEEP,
        OP_EMIT_CLOSE
    } t_op;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_DXDX,
        MS_DYDY,
        MS_TOL,
        MS_LIM,
        MS_AXDY,
        MS_AYDX,
        MS_MM,
        MS_AXAX,
        MS_AYAY,
        MS_VXX,
        MS_VYY,
        MS_CLX,
        MS_CLY
    } t_msel;

    typedef enum logic [2:0] {
        D_T1,
        D_T1ADD,
        D_T2,
        D_LIM,
        D_ACC
    } t_dst;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        t_dst  dst;
        logic  h;
        logic  first;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic acc_gt_lim;
        logic t1_gt_t2;
        logic t1_gt_eps;
        logic held_valid;
        logic chord_zero;
        logic depth_stop;
        logic sp_empty;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [7:0][CW-1:0] p;
        logic               first;
    } t_seg;

    // floor((a+b)/2)
    function automatic logic signed [CW-1:0] f_mid(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [DW-1:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[DW-1:1];
    endfunction

    function automatic logic signed [DW-1:0] f_diff(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic logic [OW-1:0] f_mag(input logic signed [DW-1:0] d);
        logic [DW-1:0] m;
        m = d[DW-1] ? DW'(-d) : DW'(d);
        return OW'(m);
    endfunction

endpackage

// ===== hdl/cbaf_if.sv =====
// valid/ready channel interfaces: segment in, vertex out, register writes
// depends on cbaf_pkg
`timescale 1ns / 1ps
interface cbaf_seg_if;
    logic                           valid;
    logic                           ready;
    logic signed [cbaf_pkg::IO_W-1:0] start_x;
    logic signed [cbaf_pkg::IO_W-1:0] start_y;
    logic signed [cbaf_pkg::IO_W-1:0] handle1_x;
    logic signed [cbaf_pkg::IO_W-1:0] handle1_y;
    logic signed [cbaf_pkg::IO_W-1:0] handle2_x;
    logic signed [cbaf_pkg::IO_W-1:0] handle2_y;
    logic signed [cbaf_pkg::IO_W-1:0] end_x;
    logic signed [cbaf_pkg::IO_W-1:0] end_y;
    logic                           first_segment;
    logic                           last_segment;
    modport source(output valid, start_x, start_y, handle1_x, handle1_y, handle2_x,
                   handle2_y, end_x, end_y, first_segment, last_segment, input ready);
    modport sink(input valid, start_x, start_y, handle1_x, handle1_y, handle2_x,
                 handle2_y, end_x, end_y, first_segment, last_segment, output ready);
endinterface

interface cbaf_vtx_if;
    logic                           valid;
    logic                           ready;
    logic signed [cbaf_pkg::IO_W-1:0] vertex_x;
    logic signed [cbaf_pkg::IO_W-1:0] vertex_y;
    logic                           has_vertex;
    logic                           path_end;
    modport source(output valid, vertex_x, vertex_y, has_vertex, path_end, input ready);
    modport sink(input valid, vertex_x, vertex_y, has_vertex, path_end, output ready);
endinterface

interface cbaf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cbaf_pkg::CFG_IDX_W-1:0]    index;
    logic [cbaf_pkg::CFG_W-1:0]        data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/cbaf_mul.sv =====
// shift-add unsigned multiplier, one operand bit per cycle
// depends on cbaf_pkg
`timescale 1ns / 1ps
module cbaf_mul (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [cbaf_pkg::OW-1:0] i_a,
    input  logic [cbaf_pkg::OW-1:0] i_b,
    output logic                   o_busy,
    output logic [cbaf_pkg::PW-1:0] o_prod
);
    import cbaf_pkg::*;

    logic [OW:0]      r_hi;
    logic [OW-1:0]    r_lo;
    logic [OW-1:0]    r_a;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [OW:0]      w_sum;

    assign w_sum  = r_hi + (r_lo[0] ? {1'b0, r_a} : '0);
    assign o_busy = r_busy;
    assign o_prod = {r_hi[OW-1:0], r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(OW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi <= '0;
            r_lo <= i_b;
            r_a  <= i_a;
        end else if (r_busy) begin
            r_hi <= {1'b0, w_sum[OW:1]};
            r_lo <= {w_sum[0], r_lo[OW-1:1]};
        end
    end

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("multiplier started while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_cnt == CNT_W'(OW)) else $error("start not taken");
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_cnt) == CNT_W'(1)) else $error("early finish");
endmodule

// ===== hdl/cbaf_dp.sv =====
// datapath: piece registers, split stack, flatness and dedup arithmetic,
// vertex hold logic, output register and config registers; depends on cbaf_pkg, cbaf_mul
`timescale 1ns / 1ps
module cbaf_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cbaf_pkg::t_seg i_seg,
    input  cbaf_pkg::t_cmd i_cmd,
    output cbaf_pkg::t_stat o_st,
    cbaf_vtx_if.source    o_vtx,
    cbaf_cfg_if.sink      i_cfg
);
    import cbaf_pkg::*;

    logic signed [CW-1:0] r_c [8];
    logic [LVL_W-1:0]     r_lvl;
    logic signed [CW-1:0] r_mem [STACK_CAP][8];
    logic [LVL_W-1:0]     r_mem_lvl [STACK_CAP];
    logic [SP_W-1:0]      r_sp;

    logic signed [CW-1:0] r_cand_x, r_cand_y, r_held_x, r_held_y, r_first_x, r_first_y;
    logic                 r_held_valid;
    logic [VCNT_W-1:0]    r_vcnt;

    logic [OW-1:0]        r_t1, r_t2, r_m;
    logic [PW-1:0]        r_lim, r_acc;

    logic [CFG_W-1:0]     r_tol, r_eps;

    logic                 r_ov, r_ohv, r_ope;
    logic signed [CW-1:0] r_ox, r_oy;

    logic signed [DW-1:0] w_dx, w_dy, w_ax, w_ay, w_vx, w_vy, w_clx, w_cly;
    logic signed [CW-1:0] w_hx, w_hy;
    logic [OW-1:0]        w_ma, w_mb, w_eps;
    logic [PW-1:0]        w_prod;
    logic                 w_mul_busy;
    logic signed [CW-1:0] w_left [8];
    logic signed [CW-1:0] w_right [8];
    logic signed [CW-1:0] w_a01 [2], w_a12 [2], w_a23 [2], w_a012 [2], w_a123 [2];
    logic signed [CW-1:0] w_a0123 [2];
    logic [IDX_W-1:0]     w_push_idx, w_pop_idx;
    logic [SP_W-1:0]      w_sp_dec;
    logic                 w_drop_close;

    assign w_hx  = i_cmd.h ? r_c[4] : r_c[2];
    assign w_hy  = i_cmd.h ? r_c[5] : r_c[3];
    assign w_dx  = f_diff(r_c[6], r_c[0]);
    assign w_dy  = f_diff(r_c[7], r_c[1]);
    assign w_ax  = f_diff(w_hx, r_c[0]);
    assign w_ay  = f_diff(w_hy, r_c[1]);
    assign w_vx  = f_diff(r_cand_x, r_held_x);
    assign w_vy  = f_diff(r_cand_y, r_held_y);
    assign w_clx = f_diff(r_held_x, r_first_x);
    assign w_cly = f_diff(r_held_y, r_first_y);
    assign w_eps = OW'(r_eps);

    assign w_sp_dec   = r_sp - SP_W'(1);
    assign w_pop_idx  = w_sp_dec[IDX_W-1:0];
    assign w_push_idx = r_sp[IDX_W-1:0];
    assign w_drop_close = (r_vcnt >= VCNT_W'(2)) && (r_t1 < w_eps);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.msel)
            MS_DXDX: begin w_ma = f_mag(w_dx);  w_mb = f_mag(w_dx);  end
            MS_DYDY: begin w_ma = f_mag(w_dy);  w_mb = f_mag(w_dy);  end
            MS_TOL:  begin w_ma = OW'(r_tol);   w_mb = OW'(r_tol);   end
            MS_LIM:  begin w_ma = r_t1;         w_mb = r_t2;         end
            MS_AXDY: begin w_ma = f_mag(w_ax);  w_mb = f_mag(w_dy);  end
            MS_AYDX: begin w_ma = f_mag(w_ay);  w_mb = f_mag(w_dx);  end
            MS_MM:   begin w_ma = r_m;          w_mb = r_m;          end
            MS_AXAX: begin w_ma = f_mag(w_ax);  w_mb = f_mag(w_ax);  end
            MS_AYAY: begin w_ma = f_mag(w_ay);  w_mb = f_mag(w_ay);  end
            MS_VXX:  begin w_ma = f_mag(w_vx);  w_mb = f_mag(w_vx);  end
            MS_VYY:  begin w_ma = f_mag(w_vy);  w_mb = f_mag(w_vy);  end
            MS_CLX:  begin w_ma = f_mag(w_clx); w_mb = f_mag(w_clx); end
            MS_CLY:  begin w_ma = f_mag(w_cly); w_mb = f_mag(w_cly); end
            default: begin w_ma = '0;           w_mb = '0;           end
        endcase
    end

    cbaf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_MUL),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_busy  (w_mul_busy),
        .o_prod  (w_prod)
    );

    // de casteljau split at t = 1/2, per axis
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_a01[i]   = f_mid(r_c[i], r_c[2+i]);
            w_a12[i]   = f_mid(r_c[2+i], r_c[4+i]);
            w_a23[i]   = f_mid(r_c[4+i], r_c[6+i]);
            w_a012[i]  = f_mid(w_a01[i], w_a12[i]);
            w_a123[i]  = f_mid(w_a12[i], w_a23[i]);
            w_a0123[i] = f_mid(w_a012[i], w_a123[i]);
            w_left[i]    = r_c[i];
            w_left[2+i]  = w_a01[i];
            w_left[4+i]  = w_a012[i];
            w_left[6+i]  = w_a0123[i];
            w_right[i]   = w_a0123[i];
            w_right[2+i] = w_a123[i];
            w_right[4+i] = w_a23[i];
            w_right[6+i] = r_c[6+i];
        end
    end

    always_comb begin
        o_st.mul_busy   = w_mul_busy;
        o_st.acc_gt_lim = r_acc > r_lim;
        o_st.t1_gt_t2   = r_t1 > r_t2;
        o_st.t1_gt_eps  = r_t1 > w_eps;
        o_st.held_valid = r_held_valid;
        o_st.chord_zero = (w_dx == '0) && (w_dy == '0);
        o_st.depth_stop = (r_lvl >= LVL_W'(MAX_DEPTH))
                        || ((SP_W+1)'(r_sp) + (SP_W+1)'(2) > (SP_W+1)'(STACK_CAP));
        o_st.sp_empty   = (r_sp == '0);
        o_st.out_free   = !r_ov;
    end

    assign o_vtx.valid      = r_ov;
    assign o_vtx.vertex_x   = IO_W'(r_ox);
    assign o_vtx.vertex_y   = IO_W'(r_oy);
    assign o_vtx.has_vertex = r_ohv;
    assign o_vtx.path_end   = r_ope;
    assign i_cfg.ready      = 1'b1;

    // piece, stack and arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                for (int k = 0; k < 8; k++) r_c[k] <= signed'(i_seg.p[k]);
                r_lvl    <= '0;
                r_cand_x <= signed'(i_seg.p[0]);
                r_cand_y <= signed'(i_seg.p[1]);
            end
            OP_POP: begin
                r_c   <= r_mem[w_pop_idx];
                r_lvl <= r_mem_lvl[w_pop_idx];
            end
            OP_SPLIT: begin
                r_mem[w_push_idx]     <= w_right;
                r_mem_lvl[w_push_idx] <= r_lvl + LVL_W'(1);
                r_c                   <= w_left;
                r_lvl                 <= r_lvl + LVL_W'(1);
            end
            OP_CAND_END: begin
                r_cand_x <= r_c[6];
                r_cand_y <= r_c[7];
            end
            OP_WB: begin
                case (i_cmd.dst)
                    D_T1:    r_t1  <= w_prod[OW-1:0];
                    D_T1ADD: r_t1  <= r_t1 + w_prod[OW-1:0];
                    D_T2:    r_t2  <= w_prod[OW-1:0];
                    D_LIM:   r_lim <= w_prod;
                    D_ACC:   r_acc <= w_prod;
                    default: r_t1  <= r_t1;
                endcase
            end
            OP_CROSS: begin
                // signed cross term magnitude from two product magnitudes
                if ((w_ax[DW-1] ^ w_dy[DW-1]) != (w_ay[DW-1] ^ w_dx[DW-1])) begin
                    r_m <= r_t1 + r_t2;
                end else if (r_t1 >= r_t2) begin
                    r_m <= r_t1 - r_t2;
                end else begin
                    r_m <= r_t2 - r_t1;
                end
            end
            default: begin
                r_lvl <= r_lvl;
            end
        endcase
        if (i_cmd.op == OP_TAKE_FIRST) begin
            r_held_x  <= r_cand_x;
            r_held_y  <= r_cand_y;
            r_first_x <= r_cand_x;
            r_first_y <= r_cand_y;
        end
        if (i_cmd.op == OP_EMIT_KEEP) begin
            r_ox     <= r_held_x;
            r_oy     <= r_held_y;
            r_ohv    <= 1'b1;
            r_ope    <= 1'b0;
            r_held_x <= r_cand_x;
            r_held_y <= r_cand_y;
        end
        if (i_cmd.op == OP_EMIT_CLOSE) begin
            r_ope <= 1'b1;
            if (w_drop_close) begin
                r_ox  <= '0;
                r_oy  <= '0;
                r_ohv <= 1'b0;
            end else begin
                r_ox  <= r_held_x;
                r_oy  <= r_held_y;
                r_ohv <= 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp         <= '0;
            r_held_valid <= 1'b0;
            r_vcnt       <= '0;
            r_ov         <= 1'b0;
            r_tol        <= TOL_RESET;
            r_eps        <= EPS_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.index == CFG_FLAT_TOL) begin
                r_tol <= i_cfg.data;
            end
            if (i_cfg.valid && i_cfg.index == CFG_DEDUP_EPS) begin
                r_eps <= i_cfg.data;
            end
            if (r_ov && o_vtx.ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_sp <= '0;
                    if (i_cmd.first) begin
                        r_held_valid <= 1'b0;
                        r_vcnt       <= '0;
                    end
                end
                OP_POP:   r_sp <= w_sp_dec;
                OP_SPLIT: r_sp <= r_sp + SP_W'(1);
                OP_TAKE_FIRST: begin
                    r_held_valid <= 1'b1;
                    r_vcnt       <= VCNT_W'(1);
                end
                OP_EMIT_KEEP: begin
                    r_ov <= 1'b1;
                    if (r_vcnt != '1) begin
                        r_vcnt <= r_vcnt + VCNT_W'(1);
                    end
                end
                OP_EMIT_CLOSE: begin
                    r_ov         <= 1'b1;
                    r_held_valid <= 1'b0;
                    r_vcnt       <= '0;
                end
                default: begin
                    r_sp <= r_sp;
                end
            endcase
        end
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_CAP)) else $error("stack pointer overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_POP |-> r_sp != '0) else $error("pop from empty stack");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT_KEEP || i_cmd.op == OP_EMIT_CLOSE) |-> !r_ov)
        else $error("output register overwritten");
    a_keep_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_EMIT_KEEP |-> r_held_valid) else $error("emit without held vertex");
endmodule

// ===== hdl/cbaf_ctrl.sv =====
// controller: sequences loads, multiplies, flatness tests, stack walk and vertex output
// depends on cbaf_pkg; drives cbaf_dp through t_cmd, reads t_stat
`timescale 1ns / 1ps
module cbaf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_first,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  cbaf_pkg::t_stat i_st,
    output cbaf_pkg::t_cmd  o_cmd
);
    import cbaf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_TEST, S_MWAIT,
        S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
        S_Z0, S_Z1, S_Z2, S_Z3,
        S_SPLIT, S_ACCEPT, S_NEXT,
        S_OFFER, S_O1, S_O2, S_O3,
        S_C0, S_C1, S_C2
    } t_state;

    t_state r_state, n_state, r_after, n_after;
    t_dst   r_dst, n_dst;
    logic   r_h, n_h, r_ret, n_ret, r_last, n_last;
    t_state w_ret_state;

    assign w_ret_state = r_ret ? S_NEXT : S_TEST;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_dst   = r_dst;
        n_h     = r_h;
        n_ret   = r_ret;
        n_last  = r_last;
        o_cmd.op    = OP_NONE;
        o_cmd.msel  = MS_NONE;
        o_cmd.dst   = r_dst;
        o_cmd.h     = r_h;
        o_cmd.first = i_in_first;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_last   = i_in_last;
                    n_ret    = 1'b0;
                    n_state  = i_in_first ? S_OFFER : S_TEST;
                end
            end
            S_MWAIT: begin
                if (!i_st.mul_busy) begin
                    o_cmd.op = OP_WB;
                    n_state  = r_after;
                end
            end
            S_TEST: begin
                n_h = 1'b0;
                if (i_st.depth_stop) begin
                    n_state = S_ACCEPT;
                end else if (i_st.chord_zero) begin
                    n_state = S_Z0;
                end else begin
                    o_cmd.op = OP_MUL; o_cmd.msel = MS_DXDX;
                    n_dst = D_T1; n_after = S_F1; n_state = S_MWAIT;
                end
            end
            S_F1: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_DYDY;
                n_dst = D_T1ADD; n_after = S_F2; n_state = S_MWAIT;
            end
            S_F2: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_TOL;
                n_dst = D_T2; n_after = S_F3; n_state = S_MWAIT;
            end
            S_F3: begin
                // tol^2 * chord^2
                o_cmd.op = OP_MUL; o_cmd.msel = MS_LIM;
                n_dst = D_LIM; n_after = S_F4; n_state = S_MWAIT;
            end
            S_F4: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_AXDY;
                n_dst = D_T1; n_after = S_F5; n_state = S_MWAIT;
            end
            S_F5: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_AYDX;
                n_dst = D_T2; n_after = S_F6; n_state = S_MWAIT;
            end
            S_F6: begin
                o_cmd.op = OP_CROSS;
                n_state  = S_F7;
            end
            S_F7: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_MM;
                n_dst = D_ACC; n_after = S_F8; n_state = S_MWAIT;
            end
            S_F8: begin
                if (i_st.acc_gt_lim) begin
                    n_state = S_SPLIT;
                end else if (!r_h) begin
                    n_h = 1'b1; n_state = S_F4;
                end else begin
                    n_state = S_ACCEPT;
                end
            end
            S_Z0: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_TOL;
                n_dst = D_T2; n_after = S_Z1; n_state = S_MWAIT;
            end
            S_Z1: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_AXAX;
                n_dst = D_T1; n_after = S_Z2; n_state = S_MWAIT;
            end
            S_Z2: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_AYAY;
                n_dst = D_T1ADD; n_after = S_Z3; n_state = S_MWAIT;
            end
            S_Z3: begin
                if (i_st.t1_gt_t2) begin
                    n_state = S_SPLIT;
                end else if (!r_h) begin
                    n_h = 1'b1; n_state = S_Z1;
                end else begin
                    n_state = S_ACCEPT;
                end
            end
            S_SPLIT: begin
                // right half goes on the stack, left half stays in the work registers
                o_cmd.op = OP_SPLIT;
                n_state  = S_TEST;
            end
            S_ACCEPT: begin
                o_cmd.op = OP_CAND_END;
                n_ret    = 1'b1;
                n_state  = S_OFFER;
            end
            S_NEXT: begin
                if (!i_st.sp_empty) begin
                    o_cmd.op = OP_POP;
                    n_state  = S_TEST;
                end else if (r_last && i_st.held_valid) begin
                    n_state = S_C0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OFFER: begin
                if (!i_st.held_valid) begin
                    o_cmd.op = OP_TAKE_FIRST;
                    n_state  = w_ret_state;
                end else begin
                    o_cmd.op = OP_MUL; o_cmd.msel = MS_VXX;
                    n_dst = D_T1; n_after = S_O1; n_state = S_MWAIT;
                end
            end
            S_O1: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_VYY;
                n_dst = D_T1ADD; n_after = S_O2; n_state = S_MWAIT;
            end
            S_O2: begin
                n_state = i_st.t1_gt_eps ? S_O3 : w_ret_state;
            end
            S_O3: begin
                if (i_st.out_free) begin
                    o_cmd.op = OP_EMIT_KEEP;
                    n_state  = w_ret_state;
                end
            end
            S_C0: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_CLX;
                n_dst = D_T1; n_after = S_C1; n_state = S_MWAIT;
            end
            S_C1: begin
                o_cmd.op = OP_MUL; o_cmd.msel = MS_CLY;
                n_dst = D_T1ADD; n_after = S_C2; n_state = S_MWAIT;
            end
            S_C2: begin
                if (i_st.out_free) begin
                    o_cmd.op = OP_EMIT_CLOSE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_dst   <= D_T1;
            r_h     <= 1'b0;
            r_ret   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_dst   <= n_dst;
            r_h     <= n_h;
            r_ret   <= n_ret;
            r_last  <= n_last;
        end
    end

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_MUL |-> !i_st.mul_busy) else $error("multiply issued while busy");
    a_wb_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_WB |-> $past(r_state) == S_MWAIT || $past(o_cmd.op) == OP_MUL)
        else $error("writeback without multiply");
    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state != S_IDLE) else $error("beat not processed");
endmodule

// ===== hdl/cubic_bezier_adaptive_flattener_top.sv =====
// channel     | dir | beat
// i_seg       | in  | one cubic segment: 4 control points q20.12, first/last flags
// o_vtx       | out | one polyline vertex or a bare end marker, path_end flag
// i_cfg       | in  | register write: index 0 tolerance, 1 dedup epsilon
//
// one segment at a time; every multiply runs on the shared shift-add multiplier,
// which sets the pace. a flatness test costs up to 10 multiplies (5 for a zero
// chord); a vertex check 2 multiplies. at most 2^MAX_DEPTH-1 pieces are tested and
// 2^MAX_DEPTH+1 vertices checked; pieces at level MAX_DEPTH skip the test.
// reset is synchronous active low and clears all control state.
// a stalled output holds the walk only when a new vertex must be emitted.
`timescale 1ns / 1ps
module cubic_bezier_adaptive_flattener_top (
    input logic        i_clk,
    input logic        i_rst_n,
    cbaf_seg_if.sink   i_seg,
    cbaf_vtx_if.source o_vtx,
    cbaf_cfg_if.sink   i_cfg
);
    import cbaf_pkg::*;

    t_seg  w_seg;
    t_cmd  w_cmd;
    t_stat w_st;
    logic  w_in_ready;

    assign w_seg.p[0]  = i_seg.start_x[CW-1:0];
    assign w_seg.p[1]  = i_seg.start_y[CW-1:0];
    assign w_seg.p[2]  = i_seg.handle1_x[CW-1:0];
    assign w_seg.p[3]  = i_seg.handle1_y[CW-1:0];
    assign w_seg.p[4]  = i_seg.handle2_x[CW-1:0];
    assign w_seg.p[5]  = i_seg.handle2_y[CW-1:0];
    assign w_seg.p[6]  = i_seg.end_x[CW-1:0];
    assign w_seg.p[7]  = i_seg.end_y[CW-1:0];
    assign w_seg.first = i_seg.first_segment;
    assign i_seg.ready = w_in_ready;

    cbaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_seg.valid),
        .i_in_first (i_seg.first_segment),
        .i_in_last  (i_seg.last_segment),
        .o_in_ready (w_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    cbaf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (w_seg),
        .i_cmd   (w_cmd),
        .o_st    (w_st),
        .o_vtx   (o_vtx),
        .i_cfg   (i_cfg)
    );
endmodule

// ===== tb/sv/tb_cubic_bezier_adaptive_flattener_top.sv =====
// self-checking testbench of the cubic bezier flattener: segment driver, vertex monitor
// and an exact-integer flattening predictor; depends on cbaf_pkg, cbaf_if and the top
`timescale 1ns / 1ps
module tb_cubic_bezier_adaptive_flattener_top;
    import cbaf_pkg::*;

    localparam int  SETTLE_CYCLES = 45000;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        longint p[8];
        bit     first;
        bit     last;
    } seg_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               hv;
        logic               pe;
    } vertex_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbaf_seg_if seg_bus();
    cbaf_vtx_if vtx_bus();
    cbaf_cfg_if cfg_bus();

    cubic_bezier_adaptive_flattener_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus),
        .o_vtx   (vtx_bus),
        .i_cfg   (cfg_bus)
    );

    always #10 i_clk = ~i_clk;

    seg_item_t pending_segs[$];
    vertex_t   expected_vertices[$];
    seg_item_t cur_seg;
    int        err_count = 0;
    bit        calm = 1'b0;
    longint    cycle_count = 0;

    // predictor state
    logic [15:0] tol_reg = TOL_RESET;
    logic [15:0] eps_reg = EPS_RESET;
    bit          held_ok = 1'b0;
    longint      held_x = 0, held_y = 0, first_x = 0, first_y = 0;
    int          kept_count = 0;

    function automatic logic [191:0] sq_dist(longint dx, longint dy);
        logic [191:0] ax, ay;
        ax = (dx < 0) ? 192'(-dx) : 192'(dx);
        ay = (dy < 0) ? 192'(-dy) : 192'(dy);
        return ax * ax + ay * ay;
    endfunction

    function automatic logic [191:0] sq_cross(longint ax, longint ay, longint dx, longint dy);
        logic signed [191:0] a, b, d, e, c;
        a = ax; b = ay; d = dx; e = dy;
        c = a * e - b * d;
        if (c < 0) c = -c;
        return c * c;
    endfunction

    function automatic bit piece_is_flat(longint c[8]);
        logic [191:0] tol2;
        longint dx, dy;
        tol2 = 192'(tol_reg) * 192'(tol_reg);
        dx = c[6] - c[0];
        dy = c[7] - c[1];
        if (dx == 0 && dy == 0)
            return sq_dist(c[2] - c[0], c[3] - c[1]) <= tol2 &&
                   sq_dist(c[4] - c[0], c[5] - c[1]) <= tol2;
        return sq_cross(c[2] - c[0], c[3] - c[1], dx, dy) <= tol2 * sq_dist(dx, dy) &&
               sq_cross(c[4] - c[0], c[5] - c[1], dx, dy) <= tol2 * sq_dist(dx, dy);
    endfunction

    function automatic void push_vertex(longint x, longint y, bit hv, bit pe);
        vertex_t v;
        v.x = x[31:0]; v.y = y[31:0]; v.hv = hv; v.pe = pe;
        expected_vertices.insert(expected_vertices.size(), v);
    endfunction

    function automatic void emit_candidate(longint x, longint y);
        if (!held_ok) begin
            held_x = x; held_y = y; first_x = x; first_y = y;
            held_ok = 1'b1;
            kept_count = 1;
            return;
        end
        if (sq_dist(x - held_x, y - held_y) > 192'(eps_reg)) begin
            push_vertex(held_x, held_y, 1'b1, 1'b0);
            held_x = x; held_y = y;
            if (kept_count < 65535) kept_count++;
        end
    endfunction

    function automatic void predict_segment(seg_item_t s);
        longint pieces[MAX_DEPTH+1][8];
        int     levels[MAX_DEPTH+1];
        int     sp, lv;
        longint c[8], l[8], r[8];
        longint a01, a12, a23, a012, a123, a0123;
        if (s.first) begin
            held_ok = 1'b0;
            kept_count = 0;
            emit_candidate(s.p[0], s.p[1]);
        end
        pieces[0] = s.p;
        levels[0] = 0;
        sp = 1;
        while (sp > 0) begin
            sp--;
            c = pieces[sp];
            lv = levels[sp];
            if (lv >= MAX_DEPTH || sp + 2 > MAX_DEPTH + 1 || piece_is_flat(c)) begin
                emit_candidate(c[6], c[7]);
                continue;
            end
            for (int i = 0; i < 2; i++) begin
                a01 = (c[i] + c[2+i]) >>> 1;
                a12 = (c[2+i] + c[4+i]) >>> 1;
                a23 = (c[4+i] + c[6+i]) >>> 1;
                a012 = (a01 + a12) >>> 1;
                a123 = (a12 + a23) >>> 1;
                a0123 = (a012 + a123) >>> 1;
                l[i] = c[i]; l[2+i] = a01; l[4+i] = a012; l[6+i] = a0123;
                r[i] = a0123; r[2+i] = a123; r[4+i] = a23; r[6+i] = c[6+i];
            end
            pieces[sp] = r; levels[sp] = lv + 1; sp++;
            pieces[sp] = l; levels[sp] = lv + 1; sp++;
        end
        if (s.last && held_ok) begin
            if (kept_count >= 2 &&
                sq_dist(held_x - first_x, held_y - first_y) < 192'(eps_reg))
                push_vertex(0, 0, 1'b0, 1'b1);
            else
                push_vertex(held_x, held_y, 1'b1, 1'b1);
            held_ok = 1'b0;
            kept_count = 0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 38);
    endfunction

    // segment driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_bus.valid <= 1'b0;
        end else begin
            if (seg_bus.valid && seg_bus.ready)
                predict_segment(cur_seg);
            if (!seg_bus.valid || seg_bus.ready) begin
                if (pending_segs.size() > 0 && !idle_roll()) begin
                    cur_seg = pending_segs.pop_front();
                    seg_bus.valid         <= 1'b1;
                    seg_bus.start_x       <= cur_seg.p[0][31:0];
                    seg_bus.start_y       <= cur_seg.p[1][31:0];
                    seg_bus.handle1_x     <= cur_seg.p[2][31:0];
                    seg_bus.handle1_y     <= cur_seg.p[3][31:0];
                    seg_bus.handle2_x     <= cur_seg.p[4][31:0];
                    seg_bus.handle2_y     <= cur_seg.p[5][31:0];
                    seg_bus.end_x         <= cur_seg.p[6][31:0];
                    seg_bus.end_y         <= cur_seg.p[7][31:0];
                    seg_bus.first_segment <= cur_seg.first;
                    seg_bus.last_segment  <= cur_seg.last;
                end else begin
                    seg_bus.valid <= 1'b0;
                end
            end
        end
    end

    // vertex monitor
    always @(posedge i_clk) begin
        vertex_t w;
        if (!i_rst_n) begin
            vtx_bus.ready <= 1'b0;
        end else begin
            if (vtx_bus.valid && vtx_bus.ready) begin
                if (expected_vertices.size() == 0) begin
                    report_mismatch("unexpected beat x", vtx_bus.vertex_x, 32'h0);
                end else begin
                    w = expected_vertices.pop_front();
                    if (vtx_bus.vertex_x !== w.x) report_mismatch("vertex_x", vtx_bus.vertex_x, w.x);
                    if (vtx_bus.vertex_y !== w.y) report_mismatch("vertex_y", vtx_bus.vertex_y, w.y);
                    if (vtx_bus.has_vertex !== w.hv)
                        report_mismatch("has_vertex", 32'(vtx_bus.has_vertex), 32'(w.hv));
                    if (vtx_bus.path_end !== w.pe)
                        report_mismatch("path_end", 32'(vtx_bus.path_end), 32'(w.pe));
                end
            end
            vtx_bus.ready <= !idle_roll();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint rnd_full();
        return longint'($signed($urandom()));
    endfunction

    function automatic longint jitter(longint base, int span);
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic void add_seg(longint q[8], bit first, bit last);
        seg_item_t s;
        s.p = q; s.first = first; s.last = last;
        pending_segs.insert(pending_segs.size(), s);
    endfunction

    // well-formed subpath: chained segments, sometimes closed back on its start
    function automatic void add_subpath();
        int     nseg, span, pick;
        longint sx, sy, cx, cy;
        longint q[8];
        nseg = $urandom_range(1, 5);
        sx = $signed($urandom_range(2 * 1048576)) - 1048576;
        sy = $signed($urandom_range(2 * 1048576)) - 1048576;
        cx = sx; cy = sy;
        for (int k = 0; k < nseg; k++) begin
            pick = $urandom_range(99);
            span = (pick < 70) ? 2000 : (pick < 96) ? 40000 : 400000;
            q[0] = cx; q[1] = cy;
            for (int i = 2; i < 8; i++) q[i] = jitter((i % 2) ? cy : cx, span);
            if (k == nseg - 1 && $urandom_range(1)) begin
                q[6] = jitter(sx, $urandom_range(1) ? 0 : 3);
                q[7] = jitter(sy, $urandom_range(1) ? 0 : 3);
            end
            add_seg(q, k == 0, k == nseg - 1);
            cx = q[6]; cy = q[7];
        end
    endfunction

    function automatic void add_noise();
        longint q[8];
        bit wide;
        wide = ($urandom_range(99) < 30);
        for (int i = 0; i < 8; i++)
            q[i] = wide ? rnd_full() : jitter(0, 3000);
        add_seg(q, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        if (idx == CFG_FLAT_TOL) tol_reg = val;
        else if (idx == CFG_DEDUP_EPS) eps_reg = val;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_segs.size() > 0 || seg_bus.valid || expected_vertices.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        longint q[8];
        seg_bus.valid = 1'b0;
        seg_bus.start_x = 0; seg_bus.start_y = 0;
        seg_bus.handle1_x = 0; seg_bus.handle1_y = 0;
        seg_bus.handle2_x = 0; seg_bus.handle2_y = 0;
        seg_bus.end_x = 0; seg_bus.end_y = 0;
        seg_bus.first_segment = 1'b0; seg_bus.last_segment = 1'b0;
        vtx_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0; cfg_bus.index = '0; cfg_bus.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset defaults
        q = '{0, 0, 0, 0, 0, 0, 0, 0};
        add_seg(q, 1'b1, 1'b1);                             // all points equal
        q = '{100, 100, 5000, 100, 100, 5000, 100, 100};
        add_seg(q, 1'b1, 1'b1);                             // zero chord, far handles
        q = '{0, 0, 100, 10, 200, -10, 300, 0};
        add_seg(q, 1'b1, 1'b0);                             // opens a subpath
        q = '{300, 0, 400, 300, 100, 400, 2, 1};
        add_seg(q, 1'b0, 1'b1);                             // closes near the start
        q = '{10, 10, 20, 20, 30, 30, 40, 40};
        add_seg(q, 1'b0, 1'b0);                             // outside a subpath
        q = '{40, 40, 50, 60, 70, 80, 9000, 9000};
        add_seg(q, 1'b1, 1'b0);                             // first while a vertex is held
        q = '{2147483647, 2147483647, -2147483647 - 1, -2147483647 - 1,
              2147483647, -2147483647 - 1, -2147483647 - 1, 2147483647};
        add_seg(q, 1'b1, 1'b1);                             // full-range extremes
        q = '{-2147483647 - 1, -2147483647 - 1, -2147483647 - 1, 2147483647,
              2147483647, 2147483647, 2147483647, -2147483647 - 1};
        add_seg(q, 1'b0, 1'b1);
        q = '{0, 0, 1, 1, 2, 2, 3, 3};
        add_seg(q, 1'b1, 1'b1);                             // tiny, collinear points
        drain();

        write_reg(CFG_FLAT_TOL, 16'd0);
        write_reg(CFG_DEDUP_EPS, 16'd0);
        write_reg(8'd2, 16'hffff);                          // index past the registers
        q = '{0, 0, 300, 0, 600, 0, 900, 0};
        add_seg(q, 1'b1, 1'b1);                             // straight line, zero tolerance
        q = '{0, 0, 300, 200, 600, -200, 900, 0};
        add_seg(q, 1'b1, 1'b1);
        q = '{5, 5, 5, 5, 5, 5, 5, 5};
        add_seg(q, 1'b1, 1'b1);
        for (int i = 0; i < 17; i++) add_subpath();
        drain();

        write_reg(CFG_FLAT_TOL, 16'hffff);
        write_reg(CFG_DEDUP_EPS, 16'hffff);
        write_reg(8'hff, 16'h1234);
        q = '{0, 0, 2147483647, 2147483647, -2147483647 - 1, 0, 0, 0};
        add_seg(q, 1'b1, 1'b1);
        calm = 1'b1;
        for (int i = 0; i < 17; i++) begin
            if ($urandom_range(9) == 0) add_noise(); else add_subpath();
        end
        drain();
        calm = 1'b0;

        write_reg(CFG_FLAT_TOL, TOL_RESET);
        write_reg(CFG_DEDUP_EPS, EPS_RESET);
        for (int i = 0; i < 19; i++) begin
            if ($urandom_range(9) == 0) add_noise(); else add_subpath();
        end
        drain();

        write_reg(CFG_FLAT_TOL, 16'($urandom_range(4000)));
        write_reg(CFG_DEDUP_EPS, 16'($urandom_range(200)));
        for (int i = 0; i < 17; i++) begin
            if ($urandom_range(9) == 0) add_noise(); else add_subpath();
        end
        drain();

        if (err_count == 0 && expected_vertices.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cbaf_pkg.sv
hdl/cbaf_if.sv
hdl/cbaf_mul.sv
hdl/cbaf_dp.sv
hdl/cbaf_ctrl.sv
hdl/cubic_bezier_adaptive_flattener_top.sv
tb/sv/tb_cubic_bezier_adaptive_flattener_top.sv
